@@ rtl/hmac_pkg.sv @@
package hmac_pkg;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_KEY  = 2'd1;
    localparam logic [1:0] PH_MSG  = 2'd2;

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5c5c5c5c;
    localparam int BLOCK_BYTES = 64;

    typedef struct packed {
        logic        op;
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
    } item_t;

    typedef struct packed {
        logic        start;
        logic        use_iv;
        logic        last;
    } comp_req_t;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] r;
        begin
            case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        begin
            k = '{
                32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
                32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
                32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
                32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
                32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
                32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
                32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
                32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
                32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
                32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
                32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
            return k[i];
        end
    endfunction

    function automatic logic [31:0] lead_mask(input logic [2:0] b);
        logic [31:0] r;
        begin
            case (b)
                3'd0: r = 32'h00000000;
                3'd1: r = 32'hff000000;
                3'd2: r = 32'hffff0000;
                3'd3: r = 32'hffffff00;
                default: r = 32'hffffffff;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/hmac_front.sv @@
module hmac_front
    import hmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  item_t       s_item,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t       buf_reg [2];
    logic [1:0]  cnt_reg;
    logic        wp_reg;
    logic        rp_reg;
    item_t       clean;
    logic        push;
    logic        pop;

    always_comb
    begin
        clean = s_item;
        if (s_item.cnt > 3'd4)
            clean.cnt = 3'd4;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= clean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/hmac_sha_core.sv @@
module hmac_sha_core
    import hmac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         use_iv,
    input  logic [511:0] block,
    output logic         busy,
    output logic [255:0] digest
);

    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   rnd_reg;
    logic         run_reg;
    logic         fin_reg;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  s0;
    logic [31:0]  s1;
    logic [31:0]  wn;
    logic [31:0]  e;
    logic [31:0]  a;

    assign busy = run_reg || fin_reg;
    assign e = v_reg[4];
    assign a = v_reg[0];

    always_comb
    begin
        t1 = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
           ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
           ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511-32*i -: 32];
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= use_iv ? iv_word(3'(i)) : h_reg[i];
                if (use_iv)
                    h_reg[i] <= iv_word(3'(i));
            end
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (fin_reg)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            rnd_reg <= 6'd0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start && !busy)
            begin
                run_reg <= 1'b1;
                rnd_reg <= 6'd0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            digest[255-32*i -: 32] = h_reg[i];
    end

endmodule

@@ rtl/hmac_back.sv @@
module hmac_back
    import hmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic [5:0]  mac_bytes,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_word,
    output logic [2:0]  m_bytes,
    output logic        m_last
);

    localparam logic [3:0] S_TAKE  = 4'd0;
    localparam logic [3:0] S_BYTE  = 4'd1;
    localparam logic [3:0] S_COMP  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_IPAD  = 4'd4;
    localparam logic [3:0] S_PAD   = 4'd5;
    localparam logic [3:0] S_LEN   = 4'd6;
    localparam logic [3:0] S_OPAD  = 4'd7;
    localparam logic [3:0] S_OUTER = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_KEYF  = 4'd10;

    localparam logic [2:0] N_BYTE = 3'd0;
    localparam logic [2:0] N_EMIT = 3'd1;
    localparam logic [2:0] N_LEN  = 3'd2;
    localparam logic [2:0] N_OPAD = 3'd3;
    localparam logic [2:0] N_OUT  = 3'd4;
    localparam logic [2:0] N_PAD2 = 3'd5;
    localparam logic [2:0] N_KEYD = 3'd6;

    logic [3:0]   st_reg;
    logic [2:0]   nx_reg;
    logic [1:0]   phase_reg;
    logic         long_reg;
    logic         iv_reg;
    logic [63:0]  cnt_reg;
    logic [511:0] key_reg;
    logic [511:0] blk_reg;
    item_t        it_reg;
    logic [2:0]   bi_reg;
    logic [3:0]   ow_reg;
    logic [5:0]   m_reg;
    logic [255:0] inner_reg;
    logic         core_start;
    logic         core_iv;
    logic [511:0] core_blk;
    logic         core_busy;
    logic [255:0] digest;
    logic [5:0]   idx;
    logic [7:0]   nb;
    logic [31:0]  dw;
    logic [5:0]   left;

    hmac_sha_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .use_iv (core_iv),
        .block  (core_blk),
        .busy   (core_busy),
        .digest (digest)
    );

    assign idx = cnt_reg[5:0];
    assign nb  = it_reg.data[31 - 8*bi_reg -: 8];
    assign q_ready = (st_reg == S_TAKE);
    assign dw = digest[255 - 32*ow_reg[2:0] -: 32];
    assign left = m_reg - {ow_reg, 2'b00};
    assign m_tvalid = (st_reg == S_EMIT);
    assign m_bytes  = (left > 6'd4) ? 3'd4 : left[2:0];
    assign m_word   = dw & lead_mask(m_bytes);
    assign m_last   = (left <= 6'd4);

    always_comb
    begin
        core_start = 1'b0;
        core_iv    = 1'b0;
        core_blk   = blk_reg;
        case (st_reg)
            S_COMP:
            begin
                core_start = 1'b1;
                core_iv    = iv_reg;
            end
            S_IPAD:
            begin
                core_start = 1'b1;
                core_iv    = 1'b1;
                core_blk   = key_reg ^ {16{IPAD}};
            end
            S_OPAD:
            begin
                core_start = 1'b1;
                core_iv    = 1'b1;
                core_blk   = key_reg ^ {16{OPAD}};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_TAKE;
            nx_reg    <= N_BYTE;
            phase_reg <= PH_IDLE;
            long_reg  <= 1'b0;
            iv_reg    <= 1'b0;
            cnt_reg   <= 64'd0;
            key_reg   <= '0;
            bi_reg    <= 3'd0;
            ow_reg    <= 4'd0;
            m_reg     <= 6'd32;
        end
        else
        begin
            case (st_reg)
                S_TAKE:
                begin
                    if (q_valid)
                    begin
                        it_reg <= q_item;
                        bi_reg <= 3'd0;
                        st_reg <= S_BYTE;
                        if (q_item.op && phase_reg != PH_MSG)
                        begin
                            phase_reg <= PH_MSG;
                            cnt_reg   <= 64'd64;
                            iv_reg    <= 1'b0;
                            st_reg    <= S_IPAD;
                            nx_reg    <= N_BYTE;
                        end
                        else if (!q_item.op && phase_reg != PH_KEY)
                        begin
                            phase_reg <= PH_KEY;
                            cnt_reg   <= 64'd0;
                            long_reg  <= 1'b0;
                            iv_reg    <= 1'b1;
                        end
                    end
                end
                S_IPAD, S_OPAD:
                    if (!core_busy)
                        st_reg <= S_WAIT;
                S_COMP:
                    if (!core_busy)
                    begin
                        iv_reg <= 1'b0;
                        st_reg <= S_WAIT;
                    end
                S_WAIT:
                begin
                    if (!core_busy)
                    begin
                        case (nx_reg)
                            N_BYTE: st_reg <= S_BYTE;
                            N_LEN:  st_reg <= S_LEN;
                            N_PAD2:
                            begin
                                blk_reg <= '0;
                                st_reg  <= S_LEN;
                            end
                            N_OPAD:
                            begin
                                inner_reg <= digest;
                                st_reg    <= S_OPAD;
                                nx_reg    <= N_OUT;
                            end
                            N_OUT:
                            begin
                                blk_reg <= {inner_reg, 32'h80000000, 192'd0, 32'd768};
                                st_reg  <= S_COMP;
                                nx_reg  <= N_EMIT;
                            end
                            N_KEYD:
                            begin
                                key_reg   <= {digest, 256'd0};
                                phase_reg <= PH_IDLE;
                                st_reg    <= S_TAKE;
                            end
                            default:
                            begin
                                ow_reg <= 4'd0;
                                m_reg  <= (mac_bytes > 6'd32) ? 6'd32 :
                                          (mac_bytes == 6'd0) ? 6'd1 : mac_bytes;
                                st_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_BYTE:
                begin
                    if ({1'b0, bi_reg} < {1'b0, it_reg.cnt})
                    begin
                        if (idx[1:0] == 2'd0)
                            blk_reg[511 - 32*idx[5:2] -: 32] <= {nb, 24'd0};
                        else
                            blk_reg[511 - 8*idx -: 8] <= nb;
                        cnt_reg <= cnt_reg + 64'd1;
                        bi_reg  <= bi_reg + 3'd1;
                        if (phase_reg == PH_KEY && cnt_reg >= 64'd64)
                            long_reg <= 1'b1;
                        if (idx == 6'd63)
                        begin
                            st_reg <= S_COMP;
                            nx_reg <= N_BYTE;
                        end
                    end
                    else if (!it_reg.last)
                        st_reg <= S_TAKE;
                    else if (phase_reg == PH_KEY && !long_reg)
                        st_reg <= S_KEYF;
                    else
                        st_reg <= S_PAD;
                end
                S_KEYF:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        if (cnt_reg[6:0] >= 7'(4*i+4))
                            key_reg[511-32*i -: 32] <= blk_reg[511-32*i -: 32];
                        else if (cnt_reg[6:0] > 7'(4*i))
                            key_reg[511-32*i -: 32] <= blk_reg[511-32*i -: 32]
                                & lead_mask(3'(cnt_reg[6:0] - 7'(4*i)));
                        else
                            key_reg[511-32*i -: 32] <= 32'd0;
                    end
                    phase_reg <= PH_IDLE;
                    st_reg    <= S_TAKE;
                end
                S_PAD:
                begin
                    if (idx[1:0] == 2'd0)
                        blk_reg[511 - 32*idx[5:2] -: 32] <= 32'h80000000;
                    else
                        blk_reg[511 - 8*idx -: 8] <= 8'h80;
                    for (int i = 0; i < 16; i++)
                        if (4'(i) > idx[5:2])
                            blk_reg[511-32*i -: 32] <= 32'd0;
                    if (idx >= 6'd56)
                    begin
                        st_reg <= S_COMP;
                        nx_reg <= N_PAD2;
                    end
                    else
                        st_reg <= S_LEN;
                end
                S_LEN:
                begin
                    blk_reg[63:0] <= {cnt_reg[60:0], 3'd0};
                    st_reg <= S_COMP;
                    nx_reg <= (phase_reg == PH_KEY) ? N_KEYD : N_OPAD;
                end
                S_EMIT:
                begin
                    if (m_tready)
                    begin
                        ow_reg <= ow_reg + 4'd1;
                        if (m_last)
                        begin
                            phase_reg <= PH_IDLE;
                            st_reg    <= S_TAKE;
                        end
                    end
                end
                default: st_reg <= S_TAKE;
            endcase
        end
    end

endmodule

@@ rtl/hmac_sha256_engine.sv @@
// HMAC-SHA256 engine.
// Input stream s_*: tdata = data_word[31:0], byte_count[34:32]; tuser = op.
// Key transactions (op 0) load the stored 64-byte key; keys over 64 bytes
// are hashed. Message transactions (op 1) are hashed under the key; the
// word with last set closes the message and the tag follows on m_* as
// ceil(mac_bytes/4) transactions, the final one with tlast; mac_bytes is
// taken as 1 when it is 0 and as 32 when it is above 32.
// Input flow: each word leaves the queue, its valid bytes are packed one
// per cycle and the word is closed; every 64 stream bytes add a compression
// (64 rounds plus start, fold and handoff) that holds the byte packing.
// After the last word the tag follows the inner finish, the outer key block
// and the outer block, with one more block to compress when the padding
// spills into a second block. A key over 64 bytes closes once its hash is stored.
// A two-entry queue lets the input run ahead while the hash back end works.
// cfg_we/cfg_data set mac_bytes (reset 32); write only when idle.
// Reset clears the key to empty and closes any open stream.
// When m_tready is low, the tag word holds and the back end waits.
module hmac_sha256_engine
    import hmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // data_word[31:0], byte_count[34:32], pad
    input  logic        s_tuser,  // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // mac_word[31:0], word_bytes[34:32], pad
    output logic        m_tlast
);

    logic [5:0]  mac_bytes_reg;
    item_t       s_item;
    item_t       q_item;
    logic        q_valid;
    logic        q_ready;
    logic [31:0] m_word;
    logic [2:0]  m_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_bytes_reg <= 6'd32;
        else if (cfg_we)
            mac_bytes_reg <= cfg_data;
    end

    assign s_item.op   = s_tuser;
    assign s_item.data = s_tdata[31:0];
    assign s_item.cnt  = s_tdata[34:32];
    assign s_item.last = s_tlast;

    assign m_tdata = {5'd0, m_bytes, m_word};

    hmac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    hmac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .mac_bytes (mac_bytes_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_word    (m_word),
        .m_bytes   (m_bytes),
        .m_last    (m_tlast)
    );

endmodule

@@ rtl/hmac_checker.sv @@
module hmac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("tag word dropped");

    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4)
        else $error("bad word_bytes");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[34:32] == 3'd4)
        else $error("short word before last");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] == 3'd1 |-> m_tdata[23:0] == 24'd0)
        else $error("unused bytes not zero");

endmodule

bind hmac_sha256_engine hmac_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ sim/tb_top.sv @@
module tb_top
    import hmac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        fin;
    } tag_word_t;

    // HMAC-SHA256 predictor with its own key, hash and stream state
    class hmac_scoreboard;
        logic [31:0] rkey [16];
        logic [31:0] hs [8];
        logic [31:0] buf_w [16];
        logic [63:0] nbytes;
        logic [1:0]  ph;
        bit          long_key;
        logic [5:0]  tag_len;
        tag_word_t   tags_due [$];
        int          errors;

        function void reset_state();
            foreach (rkey[i]) rkey[i] = '0;
            foreach (hs[i]) hs[i] = '0;
            foreach (buf_w[i]) buf_w[i] = '0;
            nbytes = '0;
            ph = PH_IDLE;
            long_key = 0;
            tag_len = 6'd32;
            tags_due.delete();
            errors = 0;
        endfunction

        function logic [31:0] rr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function logic [31:0] byte_mask(int b);
            if (b >= 4) return 32'hffffffff;
            if (b <= 0) return 32'h0;
            return ~(32'hffffffff >> (8 * b));
        endfunction

        function logic [31:0] init_val(int i);
            logic [31:0] v [8];
            v = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            return v[i];
        endfunction

        function logic [31:0] kconst(int i);
            logic [31:0] k [64];
            k = '{
                32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
                32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
                32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
                32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
                32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
                32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
                32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
                32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
                32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
                32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
                32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
            return k[i];
        endfunction

        function void compress(logic [31:0] blk [16]);
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < 64; i++)
            begin
                s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = hs[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hs[i] += v[i];
        endfunction

        function void hash_key_pad(logic [31:0] pad);
            logic [31:0] blk [16];
            for (int i = 0; i < 16; i++) blk[i] = rkey[i] ^ pad;
            for (int i = 0; i < 8; i++) hs[i] = init_val(i);
            compress(blk);
        endfunction

        function void push_byte(logic [7:0] b);
            int idx, wi, sh;
            idx = nbytes[5:0];
            wi = idx >> 2;
            sh = (3 - (idx & 3)) * 8;
            if ((idx & 3) == 0) buf_w[wi] = '0;
            buf_w[wi] = (buf_w[wi] & ~(32'hff << sh)) | (32'(b) << sh);
            nbytes++;
            if (nbytes[5:0] == 0) compress(buf_w);
        endfunction

        function void close_hash();
            int p, wi, sh;
            logic [63:0] bits;
            p = nbytes[5:0];
            bits = nbytes << 3;
            wi = p >> 2;
            sh = (3 - (p & 3)) * 8;
            buf_w[wi] = (buf_w[wi] & byte_mask(p & 3)) | (32'h80 << sh);
            for (int i = wi + 1; i < 16; i++) buf_w[i] = '0;
            if (p >= 56)
            begin
                compress(buf_w);
                foreach (buf_w[i]) buf_w[i] = '0;
            end
            buf_w[14] = bits[63:32];
            buf_w[15] = bits[31:0];
            compress(buf_w);
        endfunction

        function void set_tag_len(logic [5:0] v);
            tag_len = v;
        endfunction

        function void note_input(logic op, logic [31:0] d, logic [2:0] cnt, logic fin);
            logic [1:0] want;
            int c, m, nw, b;
            logic [31:0] inner [8];
            tag_word_t t;
            c = (cnt > 4) ? 4 : cnt;
            want = op ? PH_MSG : PH_KEY;
            if (ph != want)
            begin
                nbytes = '0;
                if (op)
                begin
                    ph = PH_MSG;
                    hash_key_pad(IPAD);
                    nbytes = 64;
                end
                else
                begin
                    ph = PH_KEY;
                    long_key = 0;
                    for (int i = 0; i < 8; i++) hs[i] = init_val(i);
                end
            end
            for (int i = 0; i < c; i++) push_byte(d[31 - 8*i -: 8]);
            if (ph == PH_KEY && nbytes > 64) long_key = 1;
            if (!fin) return;
            if (ph == PH_KEY)
            begin
                if (long_key)
                begin
                    close_hash();
                    for (int i = 0; i < 16; i++) rkey[i] = (i < 8) ? hs[i] : '0;
                end
                else
                    for (int i = 0; i < 16; i++)
                        rkey[i] = buf_w[i] & byte_mask(int'(nbytes) - 4*i);
                ph = PH_IDLE;
                return;
            end
            close_hash();
            for (int i = 0; i < 8; i++) inner[i] = hs[i];
            hash_key_pad(OPAD);
            for (int i = 0; i < 8; i++) buf_w[i] = inner[i];
            buf_w[8] = 32'h80000000;
            for (int i = 9; i < 15; i++) buf_w[i] = '0;
            buf_w[15] = 32'd768;
            compress(buf_w);
            ph = PH_IDLE;
            m = (tag_len > 32) ? 32 : (tag_len == 0 ? 1 : tag_len);
            nw = (m + 3) / 4;
            for (int i = 0; i < nw; i++)
            begin
                b = (m - 4*i > 4) ? 4 : m - 4*i;
                t.word = hs[i] & byte_mask(b);
                t.nbytes = 3'(b);
                t.fin = (i + 1 == nw);
                tags_due.push_back(t);
            end
        endfunction

        function void check_tag(logic [31:0] word, logic [2:0] nb, logic fin);
            tag_word_t e;
            if (tags_due.size() == 0)
            begin
                $display("%0t unexpected tag word: expected none actual %h/%0d/%0b",
                         $realtime, word, nb, fin);
                errors++;
                return;
            end
            e = tags_due.pop_front();
            if (word !== e.word)
            begin
                $display("%0t mac_word expected %h actual %h", $realtime, e.word, word);
                errors++;
            end
            if (nb !== e.nbytes)
            begin
                $display("%0t word_bytes expected %0d actual %0d", $realtime, e.nbytes, nb);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $display("%0t last_res expected %0b actual %0b", $realtime, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_word, byte_count, zero pad
    logic        s_tuser;   // op
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // mac_word, word_bytes, zero pad
    logic        m_tlast;

    hmac_scoreboard sb;
    int  burst_left;
    int  idle_cycles;
    bit  stall_pattern;

    hmac_sha256_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall pattern, with stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_pattern)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_tag(m_tdata[31:0], m_tdata[34:32], m_tlast);
        if (rst_n && ((m_tvalid && m_tready) || (s_tvalid && s_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if ($urandom_range(0, 299) == 0)
            stall_pattern <= ~stall_pattern;

    task automatic send_word(logic op, logic [31:0] d, logic [2:0] cnt, logic fin);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, cnt, d};
        s_tuser  <= op;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(op, d, cnt, fin);
        burst_left--;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.tags_due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_tag_len(logic [5:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_tag_len(v);
        @(posedge clk);
    endtask

    // stream of n bytes, random partial words, optional zero-count last word
    task automatic send_stream(logic op, int n);
        int c;
        while (n > 0)
        begin
            c = $urandom_range(1, 4);
            if ($urandom_range(0, 2) != 0) c = 4;
            if (c > n) c = n;
            n -= c;
            if (n == 0 && $urandom_range(0, 3) == 0)
            begin
                send_word(op, $urandom, 3'(c), 1'b0);
                send_word(op, $urandom, 3'd0, 1'b1);
            end
            else
                send_word(op, $urandom, 3'(c), n == 0);
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        stall_pattern = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message under the empty key, full tag
        send_word(1'b1, 32'h0, 3'd0, 1'b1);
        // one-byte key, extremes of data
        send_word(1'b0, 32'hffffffff, 3'd1, 1'b1);
        send_word(1'b1, 32'hffffffff, 3'd4, 1'b1);
        send_word(1'b1, 32'h00000000, 3'd3, 1'b0);
        // oversized byte counts and zero count without last
        send_word(1'b1, 32'ha5a5a5a5, 3'd7, 1'b0);
        send_word(1'b1, 32'h5a5a5a5a, 3'd0, 1'b0);
        send_word(1'b1, 32'h12345678, 3'd5, 1'b1);
        // abandoned key stream leaves the key unchanged
        send_word(1'b0, 32'hdeadbeef, 3'd4, 1'b0);
        send_word(1'b1, 32'h01020304, 3'd2, 1'b1);
        // empty key again
        send_word(1'b0, 32'h0, 3'd0, 1'b1);
        send_word(1'b1, 32'hcafef00d, 3'd6, 1'b1);
        write_tag_len(6'd1);
        send_word(1'b1, 32'h80000001, 3'd4, 1'b1);
        write_tag_len(6'd0);
        send_word(1'b1, 32'h7fffffff, 3'd4, 1'b1);
        write_tag_len(6'd63);
        // exactly 64-byte key, then long key
        send_stream(1'b0, 64);
        send_stream(1'b1, 55);
        send_stream(1'b0, 65);
        send_stream(1'b1, 56);
        write_tag_len(6'd32);

        for (int ph_i = 0; ph_i < 2; ph_i++)
        begin
            repeat (6)
            begin
                case ($urandom_range(0, 9))
                    0: send_stream(1'b0, $urandom_range(0, 70));
                    1: send_stream(1'b0, $urandom_range(1, 12));
                    2: send_word(1'($urandom_range(0, 1)), $urandom, 3'($urandom), 1'b0);
                    3: idle_sender();
                    default: send_stream(1'b1, $urandom_range(0, 20));
                endcase
                if (sb.ph == PH_MSG || $urandom_range(0, 1) == 0)
                    send_word(1'b1, $urandom, 3'($urandom_range(0, 4)), 1'b1);
            end
            write_tag_len(6'($urandom_range(1, 33)));
        end

        drain();
        if (sb.errors == 0 && sb.tags_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ hmac_sha256_engine.f @@
rtl/hmac_pkg.sv
rtl/hmac_front.sv
rtl/hmac_sha_core.sv
rtl/hmac_back.sv
rtl/hmac_sha256_engine.sv
rtl/hmac_checker.sv
sim/tb_top.sv
